// File: design/sfsc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// sfsc_pkg
// Types, codes and the symbol ROM of the split-flap symbol controller.
// ============================================================================
package sfsc_pkg;

    localparam int FUNC_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int POS_W    = 6;
    localparam int ROM_SIZE = 40;

    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;

    // item kinds
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_PRINT = 2'd1,
        FUNC_HOME  = 2'd2
    } sfsc_func_t;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_HOMING   = 2'd1,
        MODE_PRINTING = 2'd2
    } sfsc_mode_t;

    // wheel order of the symbols
    localparam logic [CHAR_W-1:0] SYMBOL_ROM [ROM_SIZE] = '{
        " ", "1", "2", "3", "4", "5", "6", "7", "8", "9",
        "0", "A", "B", "C", "D", "E", "F", "G", "H", "I",
        "J", "K", "L", "M", "N", "O", "P", "Q", "R", "S",
        "T", "U", "V", "W", "X", "Y", "Z", "-", ".", "/"
    };

    // symbol at a wheel index; zero past the ROM (caller qualifies)
    function automatic logic [CHAR_W-1:0] rom_symbol(input logic [POS_W-1:0] idx);
        logic [CHAR_W-1:0] sym;
        sym = '0;
        if (int'(idx) < ROM_SIZE)
        begin
            sym = SYMBOL_ROM[idx];
        end
        return sym;
    endfunction

endpackage

// File: design/sfsc_if.sv
`timescale 1ns / 1ps
// ============================================================================
// sfsc channel interfaces
// Valid/ready channels for command transactions and result transactions.
// ============================================================================
interface sfsc_cmd_if
    import sfsc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] letter_code;
    logic              hall_sensor;

    modport source (output valid, output func, output letter_code, output hall_sensor,
                    input ready);
    modport sink   (input valid, input func, input letter_code, input hall_sensor,
                    output ready);
endinterface

interface sfsc_res_if
    import sfsc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             relay_level;
    logic             flapped;
    logic             ready_res;
    logic [POS_W-1:0] position;
    logic             accepted;

    modport source (output valid, output relay_level, output flapped, output ready_res,
                    output position, output accepted, input ready);
    modport sink   (input valid, input relay_level, input flapped, input ready_res,
                    input position, input accepted, output ready);
endinterface

// File: design/split_flap_symbol_controller_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// split_flap_symbol_controller_unit
// Controller for one split-flap character wheel driven from a symbol ROM.
// ============================================================================
// Every command transaction (tick, print, home or unused) produces exactly one
// result transaction in the following cycle; a new command is taken every cycle
// as long as the result register is empty or being drained in the same cycle,
// so the sustained rate is one item per clock. The figure is set by the single
// result register: all state update (mode, wheel position, target character,
// relay polarity) is computed combinationally from the incoming command and
// the current state and lands together with the result at the accepting edge.
// Print and home are only accepted while idle; a print command also needs
// a character that exists among the first NUM_SYMBOLS ROM entries. Ticks move
// the wheel by at most one flap each: in homing mode until the hall sensor
// reads low, in printing mode until the symbol under the window matches.
// Wheel positions past the 40-entry ROM carry no symbol and are flapped over.
// ============================================================================
module split_flap_symbol_controller_unit
    import sfsc_pkg::*;
#(
    parameter int NUM_SYMBOLS = 40
) (
    input  logic       clk,
    input  logic       rst_n,
    sfsc_cmd_if.sink   cmd,
    sfsc_res_if.source res
);

    localparam logic [POS_W:0] NUM_SYM_W = (POS_W+1)'(NUM_SYMBOLS);

    // architectural state
    sfsc_mode_t        mode_reg,   mode_next;
    logic [POS_W-1:0]  pos_reg,    pos_next;
    logic [CHAR_W-1:0] target_reg, target_next;
    logic              relay_reg,  relay_next;

    // result register
    logic              res_valid_reg;
    logic              res_relay_reg;
    logic              res_flapped_reg;
    logic              res_ready_reg;
    logic [POS_W-1:0]  res_pos_reg;
    logic              res_accepted_reg;

    logic              in_fire;
    logic              flap_c;
    logic              accepted_c;
    logic              known_c;
    logic              sym_valid_c;
    logic [POS_W:0]    pos_inc_c;
    logic [POS_W-1:0]  pos_flap_c;

    // output register drains or is empty -> take the next command
    assign cmd.ready = !res_valid_reg || res.ready;
    assign in_fire   = cmd.valid && cmd.ready;

    // print target lookup: compare against every reachable ROM entry
    always_comb
    begin
        known_c = 1'b0;
        for (int i = 0; i < ROM_SIZE; i++)
        begin
            if ((i < NUM_SYMBOLS) && (SYMBOL_ROM[i] == cmd.letter_code))
            begin
                known_c = 1'b1;
            end
        end
    end

    // symbol under the window exists only inside ROM and wheel
    assign sym_valid_c = ({1'b0, pos_reg} < (POS_W+1)'(ROM_SIZE)) &&
                         ({1'b0, pos_reg} < NUM_SYM_W);

    // one flap: advance modulo wheel size
    assign pos_inc_c  = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign pos_flap_c = (pos_inc_c >= NUM_SYM_W) ? '0 : pos_inc_c[POS_W-1:0];

    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        target_next = target_reg;
        flap_c      = 1'b0;
        accepted_c  = 1'b0;

        unique case (sfsc_func_t'(cmd.func))
            FUNC_TICK:
            begin
                if (mode_reg == MODE_HOMING)
                begin
                    if (cmd.hall_sensor)
                    begin
                        flap_c = 1'b1;
                    end
                    else
                    begin
                        pos_next  = '0;
                        mode_next = MODE_IDLE;
                    end
                end
                else if (mode_reg == MODE_PRINTING)
                begin
                    if (!sym_valid_c || (rom_symbol(pos_reg) != target_reg))
                    begin
                        flap_c = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
            end
            FUNC_PRINT:
            begin
                if ((mode_reg == MODE_IDLE) && known_c)
                begin
                    target_next = cmd.letter_code;
                    mode_next   = MODE_PRINTING;
                    accepted_c  = 1'b1;
                end
            end
            FUNC_HOME:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    mode_next  = MODE_HOMING;
                    accepted_c = 1'b1;
                end
            end
            default:
            begin
                // unused item kind: state untouched
            end
        endcase

        if (flap_c)
        begin
            pos_next = pos_flap_c;
        end
        relay_next = relay_reg ^ flap_c;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            pos_reg       <= '0;
            target_reg    <= SPACE_CODE;
            relay_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_next;
                target_reg <= target_next;
                relay_reg  <= relay_next;
            end
            if (in_fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_relay_reg    <= relay_next;
            res_flapped_reg  <= flap_c;
            res_ready_reg    <= (mode_next == MODE_IDLE);
            res_pos_reg      <= pos_next;
            res_accepted_reg <= accepted_c;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.relay_level = res_relay_reg;
    assign res.flapped     = res_flapped_reg;
    assign res.ready_res   = res_ready_reg;
    assign res.position    = res_pos_reg;
    assign res.accepted    = res_accepted_reg;

    // ---------------------------------------------------------------- checks
    // a pending result always mirrors the live state
    a_res_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_pos_reg == pos_reg) && (res_relay_reg == relay_reg) &&
                          (res_ready_reg == (mode_reg == MODE_IDLE)))
        else $error("result register out of step with state");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, pos_reg} < NUM_SYM_W)
        else $error("wheel position beyond wheel size");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(mode_reg) && $stable(pos_reg) && $stable(relay_reg))
        else $error("state changed without a transaction");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_accepted_reg |-> !res_ready_reg && !res_flapped_reg)
        else $error("accepted command left block idle or flapped");

endmodule

// File: dv/sfsc_wheel_check.sv
`timescale 1ns / 1ps
// ============================================================================
// sfsc_wheel_check
// Tracks the wheel state from accepted command transactions, predicts each
// result and compares it field by field with the result channel.
// ============================================================================
module sfsc_wheel_check
    import sfsc_pkg::*;
#(
    parameter int NUM_SYMBOLS = 40
) (
    input  logic clk,
    input  logic rst_n,
    sfsc_cmd_if  cmd,
    sfsc_res_if  res,
    output int   outstanding,
    output int   fail_count
);

    localparam int MAX_PRINTED = 100;

    typedef struct packed {
        logic             relay_level;
        logic             flapped;
        logic             idle;
        logic [POS_W-1:0] position;
        logic             accepted;
    } wheel_report_t;

    sfsc_mode_t        wheel_mode;
    logic [POS_W-1:0]  wheel_pos;
    logic [CHAR_W-1:0] target_char;
    logic              relay_pol;

    wheel_report_t pending_reports[$];
    int            pending_count = 0;
    int            error_total = 0;

    assign outstanding = pending_count;
    assign fail_count  = error_total;

    task automatic report_mismatch(input string what, input int got, input int want);
        error_total++;
        if (error_total <= MAX_PRINTED)
        begin
            $display("[%0t] wheel check: %s got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    function automatic void flap_once();
        relay_pol = ~relay_pol;
        if (int'(wheel_pos) + 1 >= NUM_SYMBOLS)
        begin
            wheel_pos = '0;
        end
        else
        begin
            wheel_pos = wheel_pos + 1'b1;
        end
    endfunction

    // only the first NUM_SYMBOLS ROM entries are on the wheel
    function automatic logic char_on_wheel(input logic [CHAR_W-1:0] code);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < ROM_SIZE && i < NUM_SYMBOLS; i++)
        begin
            if (SYMBOL_ROM[i] == code)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic wheel_report_t next_wheel_report(input logic [FUNC_W-1:0] kind,
                                                        input logic [CHAR_W-1:0] letter,
                                                        input logic              hall);
        wheel_report_t rpt;
        logic          flap;
        logic          took;
        flap = 1'b0;
        took = 1'b0;
        case (kind)
            FUNC_TICK:
            begin
                if (wheel_mode == MODE_HOMING)
                begin
                    if (hall)
                    begin
                        flap_once();
                        flap = 1'b1;
                    end
                    else
                    begin
                        wheel_pos  = '0;
                        wheel_mode = MODE_IDLE;
                    end
                end
                else if (wheel_mode == MODE_PRINTING)
                begin
                    // slots past the ROM never match
                    if (int'(wheel_pos) >= ROM_SIZE || int'(wheel_pos) >= NUM_SYMBOLS ||
                        SYMBOL_ROM[int'(wheel_pos)] != target_char)
                    begin
                        flap_once();
                        flap = 1'b1;
                    end
                    else
                    begin
                        wheel_mode = MODE_IDLE;
                    end
                end
            end
            FUNC_PRINT:
            begin
                if (wheel_mode == MODE_IDLE && char_on_wheel(letter))
                begin
                    target_char = letter;
                    wheel_mode  = MODE_PRINTING;
                    took        = 1'b1;
                end
            end
            FUNC_HOME:
            begin
                if (wheel_mode == MODE_IDLE)
                begin
                    wheel_mode = MODE_HOMING;
                    took       = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        rpt.relay_level = relay_pol;
        rpt.flapped     = flap;
        rpt.idle        = (wheel_mode == MODE_IDLE);
        rpt.position    = wheel_pos;
        rpt.accepted    = took;
        return rpt;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        wheel_report_t want;
        if (!rst_n)
        begin
            wheel_mode  = MODE_IDLE;
            wheel_pos   = '0;
            target_char = SPACE_CODE;
            relay_pol   = 1'b0;
            pending_reports.delete();
            pending_count <= 0;
        end
        else
        begin
            // result first: it always belongs to an earlier command
            if (res.valid && res.ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    report_mismatch("result with nothing pending, position",
                                    int'(res.position), 0);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (res.relay_level !== want.relay_level)
                    begin
                        report_mismatch("relay_level", int'(res.relay_level),
                                        int'(want.relay_level));
                    end
                    if (res.flapped !== want.flapped)
                    begin
                        report_mismatch("flapped", int'(res.flapped), int'(want.flapped));
                    end
                    if (res.ready_res !== want.idle)
                    begin
                        report_mismatch("ready_res", int'(res.ready_res), int'(want.idle));
                    end
                    if (res.position !== want.position)
                    begin
                        report_mismatch("position", int'(res.position),
                                        int'(want.position));
                    end
                    if (res.accepted !== want.accepted)
                    begin
                        report_mismatch("accepted", int'(res.accepted),
                                        int'(want.accepted));
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                pending_reports.push_back(next_wheel_report(cmd.func, cmd.letter_code,
                                                            cmd.hall_sensor));
            end
            pending_count <= pending_reports.size();
        end
    end

endmodule

// File: dv/split_flap_symbol_controller_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// split_flap_symbol_controller_unit_tb
// Drives tick, print and home transactions into the wheel controller, with
// bursty sending and a stalling result sink; the wheel check predicts and
// compares every result, this module gives the verdict.
// ============================================================================
module split_flap_symbol_controller_unit_tb;
    import sfsc_pkg::*;

    localparam int NUM_SYMBOLS  = 40;
    localparam int RANDOM_ITEMS = 750;
    // worst case is far below: ~800 items, each with possible gap cycles plus
    // a choked sink (one ready in four on average)
    localparam int CYCLE_LIMIT  = 200000;
    // the result is registered in the block; spare cycles catch stray results
    // after the last expected one
    localparam int DRAIN_CYCLES = 8;

    // func code the block has no use for
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // result sink behavior, switched after each phase of random length
    typedef enum int {
        SINK_FREE,
        SINK_JITTER,
        SINK_CHOKED
    } sink_style_t;

    logic        clk = 1'b0;
    logic        rst_n;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          items_sent = 0;
    sink_style_t sink_style = SINK_FREE;
    int          sink_left = 0;
    int          outstanding;
    int          fail_count;

    sfsc_cmd_if cmd_ch();
    sfsc_res_if res_ch();

    split_flap_symbol_controller_unit #(
        .NUM_SYMBOLS(NUM_SYMBOLS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch),
        .res  (res_ch)
    );

    sfsc_wheel_check #(
        .NUM_SYMBOLS(NUM_SYMBOLS)
    ) wheel_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .res        (res_ch),
        .outstanding(outstanding),
        .fail_count (fail_count)
    );

    // 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // hard stop in case the handshake hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result sink: free-running, randomly jittered, or mostly stalled.
    // Phases are long enough that the sender's bursts overlap all three.
    always @(posedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_style <= sink_style_t'($urandom_range(0, 2));
            sink_left  <= $urandom_range(8, 64);
        end
        else
        begin
            sink_left <= sink_left - 1;
        end
        case (sink_style)
            SINK_FREE:
            begin
                res_ch.ready <= 1'b1;
            end
            SINK_JITTER:
            begin
                res_ch.ready <= ($urandom_range(0, 3) != 0);
            end
            default:
            begin
                res_ch.ready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    // One transaction. Bursts of random length; between bursts valid drops
    // for a random gap so it is never lowered and raised in one step.
    // Occasionally a long burst gives a stretch with no sender idling.
    task automatic send_item(input logic [FUNC_W-1:0] kind,
                             input logic [CHAR_W-1:0] letter,
                             input logic              hall);
        if (burst_left == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        cmd_ch.valid       <= 1'b1;
        cmd_ch.func        <= kind;
        cmd_ch.letter_code <= letter;
        cmd_ch.hall_sensor <= hall;
        do @(posedge clk); while (!cmd_ch.ready);
        items_sent++;
    endtask

    // Sender goes quiet until every pending result has come back.
    task automatic hold_until_drained();
        cmd_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial
    begin
        int                directed_count;
        int                tick_count;
        logic [CHAR_W-1:0] letter;

        rst_n              <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.func        <= FUNC_TICK;
        cmd_ch.letter_code <= SPACE_CODE;
        cmd_ch.hall_sensor <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // ticks while idle change nothing
        send_item(FUNC_TICK, 8'h00, 1'b0);
        send_item(FUNC_TICK, 8'hFF, 1'b1);
        // unused kind is ignored, both extremes of the letter
        send_item(FUNC_UNUSED, 8'hFF, 1'b1);
        send_item(FUNC_UNUSED, 8'h00, 1'b0);
        // characters not on the wheel are refused
        send_item(FUNC_PRINT, 8'h00, 1'b0);
        send_item(FUNC_PRINT, 8'hFF, 1'b1);
        send_item(FUNC_PRINT, "a", 1'b0);
        // homing: commands while busy are dropped, high sensor flaps,
        // low sensor sets home
        send_item(FUNC_HOME, 8'h00, 1'b0);
        send_item(FUNC_HOME, 8'h00, 1'b0);
        send_item(FUNC_PRINT, "A", 1'b0);
        send_item(FUNC_TICK, 8'h00, 1'b1);
        send_item(FUNC_TICK, 8'h00, 1'b1);
        send_item(FUNC_TICK, 8'h00, 1'b0);
        // symbol already under the window: first tick ends the print
        send_item(FUNC_PRINT, " ", 1'b0);
        send_item(FUNC_PRINT, "Z", 1'b0);
        send_item(FUNC_TICK, 8'h00, 1'b0);
        // one flap then a match
        send_item(FUNC_PRINT, "1", 1'b1);
        send_item(FUNC_TICK, 8'h00, 1'b1);
        send_item(FUNC_TICK, 8'h00, 1'b0);
        send_item(FUNC_TICK, 8'h00, 1'b1);
        directed_count = items_sent;

        hold_until_drained();

        // ---- random part ----
        // Mostly well-formed home / print sequences with random payload on
        // the don't-care fields, plus raw noise and refused prints.
        // Print sequences get up to 45 ticks, enough for a full turn of the
        // wheel and the matching tick, so the wrap is reached often.
        while (items_sent < directed_count + RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    send_item(FUNC_HOME, 8'($urandom), 1'($urandom));
                    tick_count = $urandom_range(0, 45);
                    repeat (tick_count)
                    begin
                        send_item(FUNC_TICK, 8'($urandom), ($urandom_range(0, 15) != 0));
                    end
                    send_item(FUNC_TICK, 8'($urandom), 1'b0);
                end
                4, 5, 6, 7:
                begin
                    letter = SYMBOL_ROM[$urandom_range(0, ROM_SIZE - 1)];
                    send_item(FUNC_PRINT, letter, 1'($urandom));
                    tick_count = $urandom_range(1, 45);
                    repeat (tick_count)
                    begin
                        // a stray command now and then, mostly while busy
                        if ($urandom_range(0, 11) == 0)
                        begin
                            send_item(FUNC_W'($urandom_range(1, 3)), 8'($urandom),
                                      1'($urandom));
                        end
                        else
                        begin
                            send_item(FUNC_TICK, 8'($urandom), 1'($urandom));
                        end
                    end
                end
                8:
                begin
                    repeat ($urandom_range(1, 8))
                    begin
                        send_item(FUNC_W'($urandom), 8'($urandom), 1'($urandom));
                    end
                end
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        hold_until_drained();
                    end
                    else
                    begin
                        send_item(FUNC_PRINT, 8'($urandom), 1'($urandom));
                    end
                end
            endcase
        end

        // ---- wrap-up ----
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        // read the checker's counts away from the clock edge
        @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: split_flap_symbol_controller_unit.f
design/sfsc_pkg.sv
design/sfsc_if.sv
design/split_flap_symbol_controller_unit.sv
dv/sfsc_wheel_check.sv
dv/split_flap_symbol_controller_unit_tb.sv
